// File: design/sch_pkg.sv
// Shared definitions for the segment/circle hit test pipeline.
// Holds the default coordinate width and the flag bundle passed between stages.
// No dependencies.
package sch_pkg;

	localparam int COORD_BITS_DEF = 16;

	// Sign and zero flags of the quadratic terms, carried alongside the wide products.
	typedef struct packed {
		logic a_zero;
		logic c_neg;
		logic h_neg;
		logic h_zero;
		logic s_neg;
	} sch_flags_t;

endpackage

// File: design/sch_setup.sv
// Front end of the hit test: differences, dot products and magnitudes (four stages).
// Depends on sch_pkg for the flag bundle.
module sch_setup #(
	parameter int N = sch_pkg::COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [N-1:0]     start_x,
	input  logic signed [N-1:0]     start_y,
	input  logic signed [N-1:0]     end_x,
	input  logic signed [N-1:0]     end_y,
	input  logic signed [N-1:0]     center_x,
	input  logic signed [N-1:0]     center_y,
	input  logic        [N-2:0]     circle_radius,
	output logic                    valid_s4,
	output logic        [2*N+2:0]   mag_h_s4,
	output logic        [2*N+2:0]   mag_a_s4,
	output logic        [2*N+2:0]   mag_c_s4,
	output logic        [2*N+2:0]   mag_s_s4,
	output sch_pkg::sch_flags_t     flags_s4
);
	import sch_pkg::*;

	localparam int MW = 2*N + 3;

	logic                  valid_s1, valid_s2, valid_s3;

	logic signed [N:0]     dx_s1, dy_s1, fx_s1, fy_s1;
	logic        [N-2:0]   r_s1;

	logic signed [2*N+1:0] dxx_s2, dyy_s2, fdx_s2, fdy_s2, fxx_s2, fyy_s2;
	logic        [2*N-3:0] rr_s2;

	logic        [2*N+1:0] a_s3;
	logic signed [2*N+2:0] h_s3, c_s3;

	logic signed [2*N+2:0] a_full;
	logic signed [2*N+3:0] s_full;
	logic signed [2*N+2:0] h_abs, c_abs;
	logic signed [2*N+3:0] s_abs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_comb begin
		a_full = dxx_s2 + dyy_s2;
		s_full = h_s3 + $signed({2'b00, a_s3});
		h_abs  = h_s3[2*N+2] ? -h_s3 : h_s3;
		c_abs  = c_s3[2*N+2] ? -c_s3 : c_s3;
		s_abs  = s_full[2*N+3] ? -s_full : s_full;
	end

	always_ff @(posedge clk) begin
		// Stage 1: direction and offset vectors.
		dx_s1 <= $signed({end_x[N-1], end_x}) - $signed({start_x[N-1], start_x});
		dy_s1 <= $signed({end_y[N-1], end_y}) - $signed({start_y[N-1], start_y});
		fx_s1 <= $signed({start_x[N-1], start_x}) - $signed({center_x[N-1], center_x});
		fy_s1 <= $signed({start_y[N-1], start_y}) - $signed({center_y[N-1], center_y});
		r_s1  <= circle_radius;

		// Stage 2: component products.
		dxx_s2 <= dx_s1 * dx_s1;
		dyy_s2 <= dy_s1 * dy_s1;
		fdx_s2 <= fx_s1 * dx_s1;
		fdy_s2 <= fy_s1 * dy_s1;
		fxx_s2 <= fx_s1 * fx_s1;
		fyy_s2 <= fy_s1 * fy_s1;
		rr_s2  <= r_s1 * r_s1;

		// Stage 3: a = d.d, h = f.d, c = f.f - r^2.
		a_s3 <= a_full[2*N+1:0];
		h_s3 <= fdx_s2 + fdy_s2;
		c_s3 <= fxx_s2 + fyy_s2 - $signed({1'b0, rr_s2});

		// Stage 4: magnitudes for the wide multipliers, with s = h + a.
		mag_h_s4        <= h_abs[MW-1:0];
		mag_a_s4        <= MW'(a_s3);
		mag_c_s4        <= c_abs[MW-1:0];
		mag_s_s4        <= s_abs[MW-1:0];
		flags_s4.a_zero <= (a_s3 == '0);
		flags_s4.c_neg  <= c_s3[2*N+2];
		flags_s4.h_neg  <= h_s3[2*N+2];
		flags_s4.h_zero <= (h_s3 == '0);
		flags_s4.s_neg  <= s_full[2*N+3];
	end

endmodule

// File: design/sch_wide_mul.sv
// Two-stage unsigned multiplier built from four half-width partial products.
// No package dependencies.
module sch_wide_mul #(
	parameter int MW = 35
) (
	input  logic            clk,
	input  logic [MW-1:0]   x,
	input  logic [MW-1:0]   y,
	output logic [2*MW-1:0] prod_s2
);

	localparam int LO = (MW + 1) / 2;
	localparam int HI = MW - LO;
	localparam int PW = 2 * MW;

	logic [2*LO-1:0]  p00_s1;
	logic [LO+HI-1:0] p01_s1, p10_s1;
	logic [2*HI-1:0]  p11_s1;

	always_ff @(posedge clk) begin
		p00_s1  <= x[LO-1:0] * y[LO-1:0];
		p01_s1  <= x[LO-1:0] * y[MW-1:LO];
		p10_s1  <= x[MW-1:LO] * y[LO-1:0];
		p11_s1  <= x[MW-1:LO] * y[MW-1:LO];
		prod_s2 <= (PW'(p11_s1) << (2*LO)) + ((PW'(p01_s1) + PW'(p10_s1)) << LO)
			+ PW'(p00_s1);
	end

endmodule

// File: design/sch_decide.sv
// Back end of the hit test: discriminant, root window compares and result strobe.
// Depends on sch_pkg for the flag bundle.
module sch_decide #(
	parameter int N = sch_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s6,
	input  sch_pkg::sch_flags_t   flags_s6,
	input  logic [4*N+5:0]        hh_s6,
	input  logic [4*N+5:0]        ac_s6,
	input  logic [4*N+5:0]        ss_s6,
	output logic                  done_s8,
	output logic                  hit_s8
);
	import sch_pkg::*;

	localparam int PW = 4*N + 6;

	logic                 valid_s7;
	sch_flags_t           flags_s7;
	logic signed [PW:0]   disc_s7;
	logic [PW-1:0]        hh_s7, ss_s7;

	logic [PW-1:0] du;
	logic          le_h, ge_h, le_s, ge_s, first, second, hit_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
			done_s8  <= 1'b0;
		end else begin
			valid_s7 <= valid_s6;
			done_s8  <= valid_s7;
		end
	end

	// The roots lie in [0,1] when the square root of the discriminant falls inside
	// windows bounded by |h| and |h + a|; each bound is tested by comparing squares.
	always_comb begin
		du       = disc_s7[PW-1:0];
		le_h     = (du <= hh_s7);
		ge_h     = (du >= hh_s7);
		le_s     = (du <= ss_s7);
		ge_s     = (du >= ss_s7);
		first    = (flags_s7.h_neg | flags_s7.h_zero) & le_h & (!flags_s7.s_neg | ge_s);
		second   = (flags_s7.h_neg | flags_s7.h_zero | ge_h) & !flags_s7.s_neg & le_s;
		hit_next = !flags_s7.a_zero & !disc_s7[PW] & (first | second);
	end

	always_ff @(posedge clk) begin
		flags_s7 <= flags_s6;
		hh_s7    <= hh_s6;
		ss_s7    <= ss_s6;
		if (flags_s6.c_neg) begin
			disc_s7 <= $signed({1'b0, hh_s6}) + $signed({1'b0, ac_s6});
		end else begin
			disc_s7 <= $signed({1'b0, hh_s6}) - $signed({1'b0, ac_s6});
		end
		hit_s8 <= hit_next;
	end

endmodule

// File: design/segment_circle_hit_test_core.sv
// Top level of the segment/circle hit test pipeline.
// Depends on sch_pkg, sch_setup, sch_wide_mul and sch_decide.

// The core takes one test per clock: a transfer happens whenever start is high, and
// busy is never raised. Each test comes out as a one-cycle done strobe with hit
// valid alongside, after passing the eight register stages (vector setup, products,
// sums, magnitudes, two for the split wide multipliers, discriminant, compares).
// Results cannot be held off, so the receiver must take every done pulse; tests
// leave in the order they entered.
module segment_circle_hit_test_core #(
	parameter int COORD_BITS = sch_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [COORD_BITS-1:0]   start_x,
	input  logic signed [COORD_BITS-1:0]   start_y,
	input  logic signed [COORD_BITS-1:0]   end_x,
	input  logic signed [COORD_BITS-1:0]   end_y,
	input  logic signed [COORD_BITS-1:0]   center_x,
	input  logic signed [COORD_BITS-1:0]   center_y,
	input  logic        [COORD_BITS-2:0]   circle_radius,
	output logic                           done,
	output logic                           hit
);
	import sch_pkg::*;

	localparam int MW = 2*COORD_BITS + 3;
	localparam int PW = 2*MW;

	logic             valid_s4, valid_s5, valid_s6;
	sch_flags_t       flags_s4, flags_s5, flags_s6;
	logic [MW-1:0]    mag_h_s4, mag_a_s4, mag_c_s4, mag_s_s4;
	logic [PW-1:0]    hh_s6, ac_s6, ss_s6;

	assign busy = 1'b0;

	sch_setup #(.N(COORD_BITS)) u_setup (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (start),
		.start_x       (start_x),
		.start_y       (start_y),
		.end_x         (end_x),
		.end_y         (end_y),
		.center_x      (center_x),
		.center_y      (center_y),
		.circle_radius (circle_radius),
		.valid_s4      (valid_s4),
		.mag_h_s4      (mag_h_s4),
		.mag_a_s4      (mag_a_s4),
		.mag_c_s4      (mag_c_s4),
		.mag_s_s4      (mag_s_s4),
		.flags_s4      (flags_s4)
	);

	// h^2, |a*c| and (h+a)^2; the squares of -h and -(h+a) are the same values.
	sch_wide_mul #(.MW(MW)) u_mul_hh (
		.clk     (clk),
		.x       (mag_h_s4),
		.y       (mag_h_s4),
		.prod_s2 (hh_s6)
	);

	sch_wide_mul #(.MW(MW)) u_mul_ac (
		.clk     (clk),
		.x       (mag_a_s4),
		.y       (mag_c_s4),
		.prod_s2 (ac_s6)
	);

	sch_wide_mul #(.MW(MW)) u_mul_ss (
		.clk     (clk),
		.x       (mag_s_s4),
		.y       (mag_s_s4),
		.prod_s2 (ss_s6)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		flags_s5 <= flags_s4;
		flags_s6 <= flags_s5;
	end

	sch_decide #(.N(COORD_BITS)) u_decide (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s6 (valid_s6),
		.flags_s6 (flags_s6),
		.hh_s6    (hh_s6),
		.ac_s6    (ac_s6),
		.ss_s6    (ss_s6),
		.done_s8  (done),
		.hit_s8   (hit)
	);

endmodule

// File: bench/sch_hit_checker.sv
// Checker for the segment/circle hit test core: predicts the hit flag of every
// accepted test and compares it with the result strobes in order of arrival.
// Depends on sch_pkg for the coordinate width.
module sch_hit_checker (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	input  logic                                         busy,
	input  logic signed [sch_pkg::COORD_BITS_DEF-1:0]    start_x,
	input  logic signed [sch_pkg::COORD_BITS_DEF-1:0]    start_y,
	input  logic signed [sch_pkg::COORD_BITS_DEF-1:0]    end_x,
	input  logic signed [sch_pkg::COORD_BITS_DEF-1:0]    end_y,
	input  logic signed [sch_pkg::COORD_BITS_DEF-1:0]    center_x,
	input  logic signed [sch_pkg::COORD_BITS_DEF-1:0]    center_y,
	input  logic        [sch_pkg::COORD_BITS_DEF-2:0]    circle_radius,
	input  logic                                         done,
	input  logic                                         hit,
	output int                                           outstanding,
	output int                                           fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = sch_pkg::COORD_BITS_DEF;

	typedef logic signed [CB-1:0] coord_t;
	typedef logic        [CB-2:0] radius_t;
	typedef logic signed [127:0]  wide_t;

	bit expected_hits[$];

	// sqrt(disc) <= bound, with disc known to be non-negative.
	function automatic bit root_at_most(wide_t disc, wide_t bound);
		return (bound >= 0) && (disc <= bound * bound);
	endfunction

	// sqrt(disc) >= bound, with disc known to be non-negative.
	function automatic bit root_at_least(wide_t disc, wide_t bound);
		return (bound <= 0) || (disc >= bound * bound);
	endfunction

	function automatic bit segment_meets_circle(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
						  coord_t cx, coord_t cy, radius_t r);
		wide_t sxw, syw, exw, eyw, cxw, cyw, rw;
		wide_t dx, dy, fx, fy, a, h, c, disc;
		bit near_root, far_root;
		sxw = sx;
		syw = sy;
		exw = ex;
		eyw = ey;
		cxw = cx;
		cyw = cy;
		rw = 0;
		rw[CB-2:0] = r;
		dx = exw - sxw;
		dy = eyw - syw;
		fx = sxw - cxw;
		fy = syw - cyw;
		a = dx * dx + dy * dy;
		h = fx * dx + fy * dy;
		c = fx * fx + fy * fy - rw * rw;
		if (a == 0)
			return 1'b0;
		disc = h * h - a * c;
		if (disc < 0)
			return 1'b0;
		// Roots are t = (-h -/+ sqrt(disc)) / a; each is tested against [0,1] exactly.
		near_root = root_at_most(disc, -h) && root_at_least(disc, -h - a);
		far_root = root_at_least(disc, h) && root_at_most(disc, a + h);
		return near_root || far_root;
	endfunction

	always @(posedge clk) begin
		bit want;
		if (arst_n) begin
			if (done) begin
				if (expected_hits.size() == 0) begin
					$error("hit: result with no test outstanding, actual %0b", hit);
					fail_count++;
				end else begin
					want = expected_hits.pop_front();
					if (hit !== want) begin
						$error("hit mismatch: expected %0b, actual %0b", want, hit);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				expected_hits = {expected_hits,
						 segment_meets_circle(start_x, start_y, end_x, end_y,
								      center_x, center_y, circle_radius)};
			outstanding = expected_hits.size();
		end
	end

endmodule

// File: bench/tb_top.sv
// Top of the segment/circle hit test bench: clock, reset, stimulus and verdict.
// Depends on sch_pkg, segment_circle_hit_test_core and sch_hit_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = sch_pkg::COORD_BITS_DEF;
	localparam int RANDOM_TESTS = 1500;
	localparam int IDLE_LIMIT = 500;
	localparam int DRAIN_CYCLES = 16;

	typedef logic signed [CB-1:0] coord_t;
	typedef logic        [CB-2:0] radius_t;

	localparam coord_t C_MIN = {1'b1, {(CB-1){1'b0}}};
	localparam coord_t C_MAX = {1'b0, {(CB-1){1'b1}}};
	localparam radius_t R_MAX = {(CB-1){1'b1}};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	coord_t start_x, start_y, end_x, end_y, center_x, center_y;
	radius_t circle_radius;
	logic done;
	logic hit;
	int outstanding;
	int fail_count;
	int idle_cycles;

	segment_circle_hit_test_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.center_x(center_x),
		.center_y(center_y),
		.circle_radius(circle_radius),
		.done(done),
		.hit(hit)
	);

	sch_hit_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.center_x(center_x),
		.center_y(center_y),
		.circle_radius(circle_radius),
		.done(done),
		.hit(hit),
		.outstanding(outstanding),
		.fail_count(fail_count)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Ends the run if neither a test nor a result moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Holds start high until the core takes the test; start stays high afterward.
	task automatic apply_test(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
				  coord_t cx, coord_t cy, radius_t r);
		@(negedge clk);
		start <= 1'b1;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		center_x <= cx;
		center_y <= cy;
		circle_radius <= r;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Idle cycles with junk on start_x, end_y and circle_radius.
	task automatic idle_gap(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
			start_x <= coord_t'($urandom);
			end_y <= coord_t'($urandom);
			circle_radius <= radius_t'($urandom);
		end
	endtask

	task automatic wait_until_drained();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	function automatic coord_t corner_coord();
		case ($urandom_range(0, 5))
			0: return C_MIN;
			1: return C_MAX;
			2: return coord_t'(0);
			3: return coord_t'(-1);
			4: return coord_t'(1);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic coord_t near_coord(int base, int span);
		return coord_t'(base + int'($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic random_test();
		coord_t sx, sy, ex, ey, cx, cy;
		radius_t r;
		int bx, by, span;
		case ($urandom_range(0, 3))
			0: begin
				sx = coord_t'($urandom);
				sy = coord_t'($urandom);
				ex = coord_t'($urandom);
				ey = coord_t'($urandom);
				cx = coord_t'($urandom);
				cy = coord_t'($urandom);
				r = radius_t'($urandom);
			end
			1: begin
				sx = corner_coord();
				sy = corner_coord();
				ex = corner_coord();
				ey = corner_coord();
				cx = corner_coord();
				cy = corner_coord();
				case ($urandom_range(0, 3))
					0: r = '0;
					1: r = R_MAX;
					2: r = radius_t'(1);
					default: r = radius_t'($urandom);
				endcase
			end
			default: begin
				// Segment and circle on a common scale, so that hits, misses,
				// tangents and endpoints on the circle all turn up.
				span = 1 << $urandom_range(2, 14);
				bx = int'(coord_t'($urandom));
				by = int'(coord_t'($urandom));
				sx = near_coord(bx, span);
				sy = near_coord(by, span);
				ex = near_coord(bx, span);
				ey = near_coord(by, span);
				cx = near_coord(bx, span);
				cy = near_coord(by, span);
				r = radius_t'($urandom_range(0, span));
				if ($urandom_range(0, 7) == 0) begin
					ex = sx;
					ey = sy;
				end
			end
		endcase
		apply_test(sx, sy, ex, ey, cx, cy, r);
	endtask

	initial begin
		int sent;
		int burst;
		bit paused;
		arst_n = 1'b0;
		start = 1'b0;
		start_x = '0;
		start_y = '0;
		end_x = '0;
		end_y = '0;
		center_x = '0;
		center_y = '0;
		circle_radius = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Diagonal across the whole coordinate range through a maximal circle.
		apply_test(C_MIN, C_MIN, C_MAX, C_MAX, 16'sd0, 16'sd0, R_MAX);
		apply_test(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, R_MAX);
		apply_test(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, '0);
		apply_test(C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, '0);
		// Degenerate segments: one inside the circle, and two on it (the last on a zero circle).
		apply_test(16'sd3, 16'sd4, 16'sd3, 16'sd4, 16'sd0, 16'sd0, 15'd10);
		apply_test(16'sd3, 16'sd4, 16'sd3, 16'sd4, 16'sd0, 16'sd0, 15'd5);
		apply_test(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, '0);
		// Line far from the circle, so the discriminant is negative.
		apply_test(-16'sd100, 16'sd50, 16'sd100, 16'sd50, 16'sd0, 16'sd0, 15'd10);
		// Segment wholly inside the circle.
		apply_test(-16'sd2, 16'sd1, 16'sd3, -16'sd1, 16'sd0, 16'sd0, 15'd20);
		// Tangent lines, touching point on and off the segment.
		apply_test(-16'sd10, 16'sd5, 16'sd10, 16'sd5, 16'sd0, 16'sd0, 15'd5);
		apply_test(16'sd10, 16'sd5, 16'sd20, 16'sd5, 16'sd0, 16'sd0, 15'd5);
		apply_test(16'sd0, 16'sd5, 16'sd7, 16'sd5, 16'sd0, 16'sd0, 15'd5);
		// Zero radius, through the center, just missing it, and ending on it.
		apply_test(-16'sd3, 16'sd0, 16'sd3, 16'sd0, 16'sd0, 16'sd0, 15'd0);
		apply_test(-16'sd3, 16'sd1, 16'sd3, 16'sd1, 16'sd0, 16'sd0, 15'd0);
		apply_test(16'sd0, 16'sd0, 16'sd4, 16'sd4, 16'sd4, 16'sd4, 15'd0);
		// Endpoints exactly on the circle, and crossings beyond either end.
		apply_test(16'sd0, 16'sd0, 16'sd5, 16'sd0, 16'sd10, 16'sd0, 15'd5);
		apply_test(16'sd5, 16'sd0, 16'sd9, 16'sd0, 16'sd0, 16'sd0, 15'd5);
		apply_test(16'sd20, 16'sd0, 16'sd30, 16'sd0, 16'sd0, 16'sd0, 15'd5);
		apply_test(-16'sd30, 16'sd0, -16'sd20, 16'sd0, 16'sd0, 16'sd0, 15'd5);
		// One end inside, one outside.
		apply_test(16'sd1, 16'sd1, 16'sd40, -16'sd7, 16'sd0, 16'sd0, 15'd12);
		wait_until_drained();

		sent = 0;
		paused = 1'b0;
		while (sent < RANDOM_TESTS) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && sent < RANDOM_TESTS; i++) begin
				random_test();
				sent++;
			end
			if (!paused && sent >= RANDOM_TESTS / 2) begin
				wait_until_drained();
				paused = 1'b1;
			end else if ($urandom_range(0, 3) != 0) begin
				idle_gap($urandom_range(1, 12));
			end
		end

		wait_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: segment_circle_hit_test_core.f
design/sch_pkg.sv
design/sch_setup.sv
design/sch_wide_mul.sv
design/sch_decide.sv
design/segment_circle_hit_test_core.sv
bench/sch_hit_checker.sv
bench/tb_top.sv
